/* hdl/lru_k_frame_replacer_defines.svh */
// Assertion macros shared by the checker.
`ifndef LRU_K_FRAME_REPLACER_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_DEFINES_SVH
`define LKFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LKFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/lkfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lkfr_pkg;
  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_SET_EVICT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_EVICT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DONE
  } state_t;

  localparam logic [0:0] REG_K_DEPTH = 1'd0;
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'd1;
endpackage
`default_nettype wire

/* hdl/lkfr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lkfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/lru_k_frame_replacer.sv */
`timescale 1ns / 1ps
// One request is handled at a time. Record, set evictable and remove pass through
// a history memory read step, a write step and the output register; only record
// writes the history memory. Evict walks every frame's history row through the
// single read port of the history memory, one frame per cycle. The result waits
// in an output register, and the next request is taken in the cycle after it has
// been delivered. The history row of each frame holds MAX_K stamps in one memory
// word, oldest first.
`default_nettype none
module lru_k_frame_replacer #(
  parameter int FRAME_COUNT = 16,
  parameter int MAX_K = 4,
  parameter int STAMP_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // mode[1:0], frame[9:2], evictable[10], zero fill
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // success[0], victim_frame[4:1], evictable_count[9:5], bad_frame[10], zero fill
  output logic      [15:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:2]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam int HW = $clog2(MAX_K + 1);
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int RW = STAMP_WIDTH * MAX_K;

  logic [2:0] k_depth;
  logic [4:0] frames_in_use;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      lkfr_pkg::REG_K_DEPTH: prdata = {29'd0, k_depth};
      default: prdata = {27'd0, frames_in_use};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_depth <= 3'd2;
      frames_in_use <= 5'd16;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        lkfr_pkg::REG_K_DEPTH: k_depth <= pwdata[2:0];
        default: frames_in_use <= pwdata[4:0];
      endcase
    end
  end

  logic [HW-1:0] eff_k;
  logic [8:0] limit;
  always_comb begin
    if (k_depth == 3'd0) begin
      eff_k = HW'(1);
    end else if (32'(k_depth) > MAX_K) begin
      eff_k = HW'(MAX_K);
    end else begin
      eff_k = HW'(k_depth);
    end
    if (32'(frames_in_use) > FRAME_COUNT) begin
      limit = 9'(FRAME_COUNT);
    end else begin
      limit = 9'(frames_in_use);
    end
  end

  lkfr_pkg::state_t state, state_next;
  lkfr_pkg::mode_t mode;
  logic [FW-1:0] fsel;
  logic valid_id, ev_in;
  logic [STAMP_WIDTH-1:0] timestamp;
  logic [HW-1:0] hcount [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] eflags;
  logic [CW-1:0] etotal;

  logic [FW-1:0] scan_idx;
  logic best_found;
  logic [1:0] best_tier;
  logic [STAMP_WIDTH-1:0] best_age;
  logic [FW-1:0] best_id;
  logic [FW-1:0] rd_id;

  logic ram_we;
  logic [FW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  lkfr_ram #(.WIDTH(RW), .DEPTH(1 << FW)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic accept;
  assign s_tready = (state == lkfr_pkg::ST_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    ram_raddr = (state == lkfr_pkg::ST_IDLE) ? FW'(0) : scan_idx;
    unique case (state)
      lkfr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (lkfr_pkg::mode_t'(s_tdata[1:0]) == lkfr_pkg::MODE_EVICT) ?
                       lkfr_pkg::ST_SCAN : lkfr_pkg::ST_READ;
        end
      end
      lkfr_pkg::ST_READ: begin
        ram_raddr = fsel;
        state_next = lkfr_pkg::ST_WRITE;
      end
      lkfr_pkg::ST_WRITE: state_next = lkfr_pkg::ST_DONE;
      lkfr_pkg::ST_SCAN: begin
        if (32'(scan_idx) == FRAME_COUNT - 1) begin
          state_next = lkfr_pkg::ST_SCAN_LAST;
        end
      end
      lkfr_pkg::ST_SCAN_LAST: state_next = lkfr_pkg::ST_DONE;
      default: state_next = lkfr_pkg::ST_IDLE;
    endcase
  end

  // History row update for a record request.
  logic [HW-1:0] n_cur;
  logic [RW-1:0] row_new;
  logic [HW-1:0] n_new;
  always_comb begin
    n_cur = (32'(hcount[fsel]) > MAX_K) ? HW'(MAX_K) : hcount[fsel];
    row_new = ram_rdata;
    n_new = n_cur + HW'(1);
    if (n_cur >= eff_k) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (HW'(i) + HW'(1) < eff_k) begin
          row_new[i*STAMP_WIDTH +: STAMP_WIDTH] =
            ram_rdata[(i + int'(n_cur) - int'(eff_k) + 1)*STAMP_WIDTH +: STAMP_WIDTH];
        end
      end
      n_new = eff_k;
    end
    for (int i = 0; i < MAX_K; i++) begin
      if (HW'(i) + HW'(1) == n_new) begin
        row_new[i*STAMP_WIDTH +: STAMP_WIDTH] = timestamp;
      end
    end
  end

  assign ram_we = (state == lkfr_pkg::ST_WRITE) && (mode == lkfr_pkg::MODE_RECORD) && valid_id;
  assign ram_waddr = fsel;
  assign ram_wdata = row_new;

  // Scoring of the row read in the previous cycle.
  logic [HW-1:0] n_rd;
  logic [1:0] tier;
  logic [KW-1:0] sidx;
  logic [STAMP_WIDTH-1:0] age;
  logic better;
  always_comb begin
    n_rd = (32'(hcount[rd_id]) > MAX_K) ? HW'(MAX_K) : hcount[rd_id];
    if (n_rd == HW'(0)) begin
      tier = 2'd2;
      sidx = KW'(0);
    end else if (n_rd < eff_k) begin
      tier = 2'd1;
      sidx = KW'(0);
    end else begin
      tier = 2'd0;
      sidx = KW'(n_rd - eff_k);
    end
    age = (tier == 2'd2) ? '0 :
          timestamp - ram_rdata[sidx*STAMP_WIDTH +: STAMP_WIDTH];
    better = eflags[rd_id] &&
             (!best_found || tier > best_tier || (tier == best_tier && age > best_age));
  end

  logic scoring;
  assign scoring = (state == lkfr_pkg::ST_SCAN && scan_idx != FW'(0)) ||
                   (state == lkfr_pkg::ST_SCAN_LAST);

  logic res_success, res_bad;
  logic [3:0] res_victim;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkfr_pkg::ST_IDLE;
      timestamp <= '0;
      eflags <= '0;
      etotal <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        hcount[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        lkfr_pkg::ST_IDLE: begin
          if (accept) begin
            mode <= lkfr_pkg::mode_t'(s_tdata[1:0]);
            valid_id <= {1'b0, s_tdata[9:2]} < limit;
            fsel <= ({1'b0, s_tdata[9:2]} < limit) ? FW'(s_tdata[9:2]) : FW'(0);
            ev_in <= s_tdata[10];
            timestamp <= timestamp + STAMP_WIDTH'(1);
            scan_idx <= FW'(0);
            best_found <= 1'b0;
            res_success <= 1'b0;
            res_bad <= 1'b0;
            res_victim <= 4'd0;
          end
        end
        lkfr_pkg::ST_WRITE: begin
          unique case (mode)
            lkfr_pkg::MODE_RECORD: begin
              if (valid_id) begin
                hcount[fsel] <= n_new;
                res_success <= 1'b1;
              end else begin
                res_bad <= 1'b1;
              end
            end
            lkfr_pkg::MODE_SET_EVICT: begin
              if (valid_id) begin
                if (eflags[fsel] && !ev_in) etotal <= etotal - CW'(1);
                else if (!eflags[fsel] && ev_in) etotal <= etotal + CW'(1);
                eflags[fsel] <= ev_in;
                res_success <= 1'b1;
              end else begin
                res_bad <= 1'b1;
              end
            end
            default: begin
              if (valid_id && eflags[fsel]) begin
                hcount[fsel] <= '0;
                eflags[fsel] <= 1'b0;
                etotal <= etotal - CW'(1);
                res_success <= 1'b1;
              end
            end
          endcase
        end
        lkfr_pkg::ST_SCAN, lkfr_pkg::ST_SCAN_LAST: begin
          rd_id <= scan_idx;
          if (state == lkfr_pkg::ST_SCAN && 32'(scan_idx) != FRAME_COUNT - 1) begin
            scan_idx <= scan_idx + FW'(1);
          end
          if (scoring && better) begin
            best_found <= 1'b1;
            best_tier <= tier;
            best_age <= age;
            best_id <= rd_id;
          end
        end
        lkfr_pkg::ST_DONE: begin
          if (mode == lkfr_pkg::MODE_EVICT && best_found) begin
            hcount[best_id] <= '0;
            eflags[best_id] <= 1'b0;
            etotal <= etotal - CW'(1);
            res_success <= 1'b1;
            res_victim <= 4'(best_id);
          end
          m_tvalid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // With a single frame the scan ends at once, and its only row is scored in
  // SCAN_LAST, in the cycle after it was read.
  assign m_tdata = {5'd0, res_bad, 5'(etotal), res_victim, res_success};
endmodule
`default_nettype wire

/* hdl/lkfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "lru_k_frame_replacer_defines.svh"
module lkfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  `LKFR_ASSERT_IMPL(a_no_take_while_full, m_tvalid, !s_tready, "request taken while result waits")
  `LKFR_ASSERT_NEXT(a_accept_closes, s_tvalid && s_tready, !s_tready, "second request taken")
  `LKFR_ASSERT_IMPL(a_bad_no_success, m_tvalid, !(m_tdata[10] && m_tdata[0]), "bad frame with success")
  `LKFR_ASSERT_IMPL(a_count_range, m_tvalid, m_tdata[9:5] <= 5'd16, "count out of range")
endmodule
bind lru_k_frame_replacer lkfr_checker u_lkfr_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* test/lru_k_frame_replacer_checker.sv */
`timescale 1ns / 1ps
module lru_k_frame_replacer_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:2]  paddr,
  input logic [31:0] pwdata,
  output int         fail_count,
  output int         pending,
  output int         result_count
);
  localparam int FRAMES = 16;
  localparam int DEPTH = 4;

  typedef struct packed {
    logic       bad;
    logic [4:0] count;
    logic [3:0] victim;
    logic       ok;
  } outcome_t;

  logic [2:0] k_reg;
  logic [4:0] limit_reg;
  logic [31:0] stamp;
  logic [31:0] hist [FRAMES][DEPTH];
  int unsigned hcount [FRAMES];
  logic [FRAMES-1:0] evict_flag;
  int unsigned evict_total;
  outcome_t awaited [$];

  function automatic int unsigned k_eff();
    if (k_reg == 0) return 1;
    if (k_reg > DEPTH) return DEPTH;
    return int'(k_reg);
  endfunction

  task automatic drop_frame(input int f);
    hcount[f] = 0;
    if (evict_flag[f]) begin
      evict_flag[f] = 1'b0;
      evict_total--;
    end
  endtask

  task automatic apply_request(input logic [15:0] req);
    lkfr_pkg::mode_t m;
    int fr, f, k, n, best, best_tier, tier, drop;
    logic [31:0] best_age, age;
    logic valid, ev;
    outcome_t o;
    m = lkfr_pkg::mode_t'(req[1:0]);
    fr = int'(req[9:2]);
    ev = req[10];
    valid = fr < ((limit_reg > FRAMES) ? FRAMES : int'(limit_reg));
    f = valid ? fr : 0;
    o = '0;
    k = k_eff();
    stamp = stamp + 32'd1;
    case (m)
      lkfr_pkg::MODE_RECORD: begin
        if (valid) begin
          n = hcount[f];
          if (n >= k) begin
            drop = n - (k - 1);
            for (int i = 0; i + 1 < k; i++) hist[f][i] = hist[f][i + drop];
            n = k - 1;
          end
          hist[f][n] = stamp;
          hcount[f] = n + 1;
          o.ok = 1'b1;
        end else o.bad = 1'b1;
      end
      lkfr_pkg::MODE_SET_EVICT: begin
        if (valid) begin
          if (evict_flag[f] && !ev) evict_total--;
          else if (!evict_flag[f] && ev) evict_total++;
          evict_flag[f] = ev;
          o.ok = 1'b1;
        end else o.bad = 1'b1;
      end
      lkfr_pkg::MODE_REMOVE: begin
        if (valid && evict_flag[f]) begin
          drop_frame(f);
          o.ok = 1'b1;
        end
      end
      default: begin
        best = -1;
        best_tier = -1;
        best_age = '0;
        for (int i = 0; i < FRAMES; i++) begin
          if (evict_flag[i]) begin
            n = hcount[i];
            if (n == 0) begin
              tier = 2;
              age = '0;
            end else if (n < k) begin
              tier = 1;
              age = stamp - hist[i][0];
            end else begin
              tier = 0;
              age = stamp - hist[i][n - k];
            end
            if (tier > best_tier || (tier == best_tier && age > best_age)) begin
              best = i;
              best_tier = tier;
              best_age = age;
            end
          end
        end
        if (best >= 0) begin
          o.ok = 1'b1;
          o.victim = best[3:0];
          drop_frame(best);
        end
      end
    endcase
    o.count = evict_total[4:0];
    awaited.push_back(o);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      k_reg <= 3'd2;
      limit_reg <= 5'd16;
      stamp = '0;
      for (int i = 0; i < FRAMES; i++) hcount[i] = 0;
      evict_flag = '0;
      evict_total = 0;
      awaited.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr == lkfr_pkg::REG_K_DEPTH) k_reg <= pwdata[2:0];
        else limit_reg <= pwdata[4:0];
      end
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        got = outcome_t'(m_tdata[10:0]);
        if (m_tdata[15:11] != 0) report("zero fill", int'(m_tdata[15:11]), 0);
        if (awaited.size() == 0) report("unexpected result", 1, 0);
        else begin
          want = awaited.pop_front();
          if (got.ok != want.ok) report("success", got.ok, want.ok);
          if (got.victim != want.victim) report("victim_frame", got.victim, want.victim);
          if (got.count != want.count) report("evictable_count", got.count, want.count);
          if (got.bad != want.bad) report("bad_frame", got.bad, want.bad);
        end
      end
      if (s_tvalid && s_tready) apply_request(s_tdata);
    end
    pending = awaited.size();
  end
endmodule

/* test/tb_lru_k_frame_replacer.sv */
`timescale 1ns / 1ps
module tb_lru_k_frame_replacer;
  localparam int QUIET_LIMIT = 5000;

  logic clk;
  logic rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [15:0] s_tdata, m_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:2] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending, result_count;
  int send_idle, recv_stall;
  int hold_off;
  int quiet;
  int sent;
  logic done;

  lru_k_frame_replacer dut (.*);

  lru_k_frame_replacer_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .pending, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("lru_k_frame_replacer regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:2] addr, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(input lkfr_pkg::mode_t m, input logic [7:0] fr, input logic ev);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, ev, fr, m};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_frame(input int lim);
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range((lim > 0) ? lim - 1 : 0));
    if (r < 93) return 8'($urandom_range(19));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(input int n, input int lim);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send(lkfr_pkg::MODE_RECORD, pick_frame(lim), 1'($urandom_range(1)));
      else if (r < 65) send(lkfr_pkg::MODE_SET_EVICT, pick_frame(lim),
                            ($urandom_range(3) != 0));
      else if (r < 78) send(lkfr_pkg::MODE_REMOVE, pick_frame(lim), 1'($urandom_range(1)));
      else send(lkfr_pkg::MODE_EVICT, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_RECORD, 8'd255, 1'b1);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd16, 1'b1);
    send(lkfr_pkg::MODE_REMOVE, 8'd16, 1'b0);
    send(lkfr_pkg::MODE_REMOVE, 8'd3, 1'b0);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd5, 1'b1);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd2, 1'b1);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd15, 1'b1);
    send(lkfr_pkg::MODE_RECORD, 8'd15, 1'b0);
    send(lkfr_pkg::MODE_RECORD, 8'd15, 1'b0);
    send(lkfr_pkg::MODE_RECORD, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd0, 1'b1);
    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_REMOVE, 8'd15, 1'b0);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd15, 1'b0);
    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_EVICT, 8'd0, 1'b0);
    send(lkfr_pkg::MODE_SET_EVICT, 8'd170, 1'b1);
    drain();

    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd4);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd16);
    random_phase(250, 16);
    drain();

    send_idle = 48;
    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd1);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd5);
    random_phase(250, 5);
    drain();

    send_idle = 0;
    recv_stall = 48;
    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd0);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd31);
    random_phase(250, 16);
    drain();

    send_idle = 10;
    recv_stall = 10;
    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd7);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd1);
    random_phase(150, 1);
    drain();
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd0);
    random_phase(50, 1);
    drain();

    send_idle = 0;
    recv_stall = 0;
    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd3);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd12);
    hold_off = 300;
    random_phase(200, 12);
    drain();

    write_reg(lkfr_pkg::REG_K_DEPTH, 32'd2);
    write_reg(lkfr_pkg::REG_FRAMES_IN_USE, 32'd16);
    random_phase(300, 16);
    drain();

    $display("Sent %0d requests and checked %0d results over several register settings,",
      sent, result_count);
    $display("covering k from 0 to 7, frame limits from 0 to 31, and stall patterns.");
    if (fail_count == 0) begin
      $display("lru_k_frame_replacer regression: pass");
    end else begin
      $display("lru_k_frame_replacer regression: fail");
    end
    $finish;
  end
endmodule

/* lru_k_frame_replacer.f */
+incdir+hdl
hdl/lkfr_pkg.sv
hdl/lkfr_ram.sv
hdl/lru_k_frame_replacer.sv
hdl/lkfr_checker.sv
test/lru_k_frame_replacer_checker.sv
test/tb_lru_k_frame_replacer.sv
